// ===== design/dct_pkg.sv =====
`timescale 1ns / 1ps
// dct_pkg: shared types and constants of the dual-channel tachometer
// used by dct_div and dual_channel_tachometer; no dependencies

package dct_pkg;

    localparam int COUNTER_BITS = 16;
    localparam int SPEED_W      = 32;
    localparam int CAP_W        = 16;
    localparam int DIV_CNT_W    = $clog2(SPEED_W);
    localparam int PADDR_W      = 3;

    localparam logic [SPEED_W-1:0] SPEED_SCALE_RESET = 32'd45000000;
    localparam logic [SPEED_W-1:0] COUNTER_SPAN      =
        SPEED_W'(64'd1 << COUNTER_BITS);
    localparam logic [CAP_W-1:0]   CAP_MASK          = (COUNTER_BITS >= CAP_W) ?
        {CAP_W{1'b1}} : CAP_W'((64'd1 << COUNTER_BITS) - 64'd1);

    // request codes
    localparam logic REQ_OVERFLOW = 1'b0;
    localparam logic REQ_CAPTURE  = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_SPEED_SCALE = 1'b0;

    typedef struct packed {
        logic             req_type;
        logic             channel;
        logic [CAP_W-1:0] capture_value;
    } t_in;

    typedef struct packed {
        logic               out_channel;
        logic [SPEED_W-1:0] speed;
        logic               zero_period;
    } t_out;

endpackage

// ===== design/dual_channel_tachometer.sv =====
`timescale 1ns / 1ps
// dual_channel_tachometer: two fan speed channels on a shared capture timer
// depends on dct_pkg and dct_div
// overflow tick: no result, ready again next cycle
// capture: divider forms one quotient bit per step, result then moves to the
//   output register; a zero period skips the divider; one item at a time
// one shared restoring divider; no new request until the result is pushed out
// sync active-low reset clears accumulators and last captures, scale 45000000

module dual_channel_tachometer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  dct_pkg::t_in                       i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output dct_pkg::t_out                      o_data,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dct_pkg::PADDR_W-1:0]        paddr,
    input  logic [dct_pkg::SPEED_W-1:0]        pwdata,
    output logic [dct_pkg::SPEED_W-1:0]        prdata,
    output logic                               pready
);
    import dct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [SPEED_W-1:0] r_scale;
    logic [SPEED_W-1:0] r_accum [2];
    logic [CAP_W-1:0]   r_last  [2];
    t_out               r_res;
    t_out               r_out;
    logic               r_out_valid;

    logic               w_accept;
    logic               w_cap_acc;
    logic               w_ovf_acc;
    logic [CAP_W-1:0]   w_cap;
    logic [SPEED_W-1:0] w_period;
    logic               w_zero;
    logic               w_div_start;
    logic               w_div_done;
    logic [SPEED_W-1:0] w_quot;
    logic               w_out_free;
    logic               w_push;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SPEED_SCALE) ? r_scale : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SPEED_SCALE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_SPEED_SCALE) begin
            r_scale <= pwdata;
        end
    end

    // input side
    assign o_ready   = (r_state == S_IDLE);
    assign w_accept  = i_valid && o_ready;
    assign w_cap_acc = w_accept && (i_data.req_type == REQ_CAPTURE);
    assign w_ovf_acc = w_accept && (i_data.req_type == REQ_OVERFLOW);
    assign w_cap     = i_data.capture_value & CAP_MASK;
    assign w_period  = r_accum[i_data.channel] + SPEED_W'(w_cap)
                     - SPEED_W'(r_last[i_data.channel]);
    assign w_zero    = (w_period == '0);
    assign w_div_start = w_cap_acc && !w_zero;

    dct_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_scale),
        .i_divisor  (w_period),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum[0] <= '0;
            r_accum[1] <= '0;
            r_last[0]  <= '0;
            r_last[1]  <= '0;
        end else if (w_ovf_acc) begin
            r_accum[0] <= r_accum[0] + COUNTER_SPAN;
            r_accum[1] <= r_accum[1] + COUNTER_SPAN;
        end else if (w_cap_acc) begin
            r_accum[i_data.channel] <= '0;
            r_last[i_data.channel]  <= w_cap;
        end
    end

    // sequencer
    assign w_out_free = !r_out_valid || i_ready;
    assign w_push     = (r_state == S_PUSH) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_cap_acc) begin
                    n_state = w_zero ? S_PUSH : S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result held here until the output register is free
    always_ff @(posedge i_clk) begin
        if (w_cap_acc) begin
            r_res.out_channel <= i_data.channel;
            r_res.speed       <= '0;
            r_res.zero_period <= w_zero;
        end else if (r_state == S_DIV && w_div_done) begin
            r_res.speed <= w_quot;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_cap_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> r_state == S_DIV)
        else $error("capture with nonzero period did not start a divide");

    a_ovf_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ovf_acc |=> r_state == S_IDLE)
        else $error("overflow tick left the sequencer busy");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH && !w_out_free) |=> r_state == S_PUSH)
        else $error("pending result dropped while output stalled");

    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> o_valid && o_data == $past(r_res))
        else $error("pushed result not presented on the output");

endmodule

// ===== design/dct_div.sv =====
`timescale 1ns / 1ps
// dct_div: restoring unsigned divider, one quotient bit per cycle
// depends on dct_pkg for the operand width

module dct_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dct_pkg::SPEED_W-1:0]  i_dividend,
    input  logic [dct_pkg::SPEED_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [dct_pkg::SPEED_W-1:0]  o_quot
);
    import dct_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SPEED_W-1:0]   r_rem;
    logic [SPEED_W-1:0]   r_quot;
    logic [SPEED_W-1:0]   r_div;

    logic [SPEED_W:0]     w_shift;
    logic [SPEED_W:0]     w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quot[SPEED_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = ~w_diff[SPEED_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(SPEED_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // remainder stays below the divisor, so its low bits are enough
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[SPEED_W-1:0] : w_shift[SPEED_W-1:0];
            r_quot <= {r_quot[SPEED_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== bench/dual_channel_tachometer_tb.sv =====
`timescale 1ns / 1ps
// dual_channel_tachometer_tb: self-checking bench for the two-channel tachometer
// predicts period and speed per capture transfer and checks every result in order
// depends on dct_pkg and the dual_channel_tachometer design

module dual_channel_tachometer_tb;
    import dct_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic [31:0] CAP_KEEP = 32'((64'd1 << COUNTER_BITS) - 64'd1);
    localparam logic [31:0] TICK_SPAN = 32'(64'd1 << COUNTER_BITS);

    class tacho_scoreboard;
        logic [31:0] scale;
        logic [31:0] accum [2];
        logic [15:0] last_cap [2];
        t_out        speeds_due [$];
        int          errors;

        function new();
            scale       = SPEED_SCALE_RESET;
            accum[0]    = '0;
            accum[1]    = '0;
            last_cap[0] = '0;
            last_cap[1] = '0;
            errors      = 0;
        endfunction

        function void set_scale(logic [31:0] value);
            scale = value;
        endfunction

        function int pending();
            return speeds_due.size();
        endfunction

        // an overflow tick moves both accumulators, a capture yields one speed
        function void note_request(t_in req);
            logic [31:0] cap;
            logic [31:0] period;
            t_out        due;
            cap = 32'(req.capture_value) & CAP_KEEP;
            if (req.req_type == REQ_OVERFLOW) begin
                accum[0] += TICK_SPAN;
                accum[1] += TICK_SPAN;
                return;
            end
            period = accum[req.channel] + cap - {16'b0, last_cap[req.channel]};
            due.out_channel = req.channel;
            due.zero_period = (period == '0);
            due.speed       = (period == '0) ? '0 : scale / period;
            last_cap[req.channel] = cap[15:0];
            accum[req.channel]    = '0;
            speeds_due.push_back(due);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (speeds_due.size() == 0) begin
                $error("result transfer with nothing expected: channel %0d speed %0d",
                       got.out_channel, got.speed);
                errors++;
                return;
            end
            want = speeds_due.pop_front();
            if (got.out_channel !== want.out_channel) begin
                $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
                errors++;
            end
            if (got.speed !== want.speed) begin
                $error("speed: expected %0d, got %0d", want.speed, got.speed);
                errors++;
            end
            if (got.zero_period !== want.zero_period) begin
                $error("zero_period: expected %0d, got %0d", want.zero_period, got.zero_period);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    t_in                  i_data;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_out                 o_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [SPEED_W-1:0]   pwdata;
    logic [SPEED_W-1:0]   prdata;
    logic                 pready;

    tacho_scoreboard tacho_sb = new();
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int cycle_count  = 0;

    dual_channel_tachometer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run exceeded %0d cycles with %0d results outstanding",
                   CYCLE_LIMIT, tacho_sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next ready at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            tacho_sb.check_result(o_data);
        i_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    function automatic t_in make_req(logic req_type, logic channel, logic [15:0] cap);
        t_in req;
        req.req_type      = req_type;
        req.channel       = channel;
        req.capture_value = cap;
        return req;
    endfunction

    // valid is only lowered for an idle cycle, so it is never lowered and raised in one step
    task automatic send_item(input t_in req);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        tacho_sb.note_request(req);
    endtask

    task automatic send_capture(input logic channel, input logic [15:0] cap);
        send_item(make_req(REQ_CAPTURE, channel, cap));
    endtask

    task automatic send_tick();
        send_item(make_req(REQ_OVERFLOW, 1'($urandom), 16'($urandom)));
    endtask

    // wait for every result, then let a trailing overflow tick settle
    task automatic drain();
        i_valid <= 1'b0;
        while (tacho_sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_SPEED_SCALE) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tacho_sb.set_scale(value);
        @(posedge i_clk);
    endtask

    // mostly realistic fan traffic: ticks between captures, with repeats that give zero periods
    function automatic t_in random_request();
        logic        channel;
        logic [15:0] cap;
        int          pick;
        channel = 1'($urandom);
        pick    = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < 35)
            return make_req(REQ_OVERFLOW, channel, 16'($urandom));
        case (pick)
            0: cap = tacho_sb.last_cap[channel];
            1: cap = 16'h0000;
            2: cap = 16'hFFFF;
            default: cap = 16'($urandom);
        endcase
        return make_req(REQ_CAPTURE, channel, cap);
    endfunction

    task automatic run_phase(input int count, input int src_pct, input int snk_pct,
                             input logic [31:0] scale);
        drain();
        write_scale(scale);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (count) send_item(random_request());
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset scale: zero period, full span, fields ignored on a tick, period wrap
        send_capture(1'b0, 16'h0000);
        send_capture(1'b1, 16'hFFFF);
        send_item(make_req(REQ_OVERFLOW, 1'b1, 16'hABCD));
        send_capture(1'b0, 16'h0000);
        send_capture(1'b1, 16'h0000);
        send_capture(1'b0, 16'hFFFF);
        send_capture(1'b0, 16'h0001);
        send_capture(1'b1, 16'h8000);

        // largest scale: period of one gives the largest speed
        drain();
        write_scale(32'hFFFF_FFFF);
        send_capture(1'b0, 16'h0002);
        send_capture(1'b0, 16'h0002);
        send_tick();
        send_capture(1'b1, 16'h5555);

        // scale of zero
        drain();
        write_scale(32'h0000_0000);
        send_capture(1'b1, 16'h5556);
        send_tick();
        send_capture(1'b1, 16'h5556);

        // scale of one
        drain();
        write_scale(32'h0000_0001);
        send_capture(1'b0, 16'h0003);
        send_capture(1'b0, 16'h0005);
        send_capture(1'b1, 16'hAAAA);

        // several spans on both accumulators before the next captures
        repeat (3) send_tick();
        send_capture(1'b0, 16'h0005);
        send_capture(1'b1, 16'h1234);

        run_phase(170, 35, 55, $urandom);
        run_phase(170, 55, 35, $urandom_range(1, 200_000));
        run_phase(170, 0, 0, SPEED_SCALE_RESET);

        drain();
        if (tacho_sb.errors == 0 && tacho_sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/dct_pkg.sv
design/dct_div.sv
design/dual_channel_tachometer.sv
bench/dual_channel_tachometer_tb.sv
